>>> rtl/sorted_set_insert_delete_unit_assert.svh
// Assertion macros for the sorted set store.
// Each macro takes a label, the clock, the reset, a condition, a check and a message.
`ifndef SORTED_SET_INSERT_DELETE_UNIT_ASSERT_SVH
`define SORTED_SET_INSERT_DELETE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// The check holds in the same cycle as the condition.
`define SSID_ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);
// The check holds in the cycle after the condition.
`define SSID_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);
`else
`define SSID_ASSERT_IMPL(label, clk, rst, pre, post, msg)
`define SSID_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

>>> rtl/ssid_pkg.sv
package ssid_pkg;

   // Store size and derived widths.
   localparam int CAPACITY = 16;
   localparam int DATA_W   = 32;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int PW       = (CNT_W > 4) ? CNT_W : 4;
   localparam int RC_W     = (CNT_W > 5) ? CNT_W : 5;

   // Operation codes.
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   // Status codes.
   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_DUP  = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_BAD  = 2'd3;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      logic compare;
      logic insert;
      logic remove;
   } ssid_cmd_type;

endpackage

>>> rtl/sorted_set_insert_delete_unit.sv
// Sorted set store built as a chain of compare-and-shift cells.
// An accepted item passes through the compare and commit states; the result strobe is registered from commit.
// A new item is taken only when idle; busy covers the compare and commit states.
// Reset clears the count, the sequencer and the strobe; entries are not cleared.
// The receiver cannot stall: each result is shown for one cycle only.
`include "sorted_set_insert_delete_unit_assert.svh"

module sorted_set_insert_delete_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_op,
   input  logic signed [ssid_pkg::DATA_W-1:0]  req_value,
   input  logic [3:0]                          req_position,
   output logic                                rsp_strobe,
   output logic [1:0]                          rsp_status,
   output logic [4:0]                          rsp_count,
   output logic [3:0]                          rsp_where
);
   import ssid_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_CMP    = 2'd1;
   localparam logic [1:0] S_COMMIT = 2'd2;

   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

   logic [1:0]               state_ff, state_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     op_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic [3:0]               pos_ff;
   logic                     strobe_ff, strobe_in;
   logic [1:0]               status_ff, status_in;
   logic [RC_W-1:0]          count_ff, count_in;
   logic [3:0]               where_ff, where_in;

   ssid_cmd_type             cmd;
   logic signed [DATA_W-1:0] entries [CAPACITY];
   logic [CAPACITY-1:0]      lt, eq, boundary, here_valid, del_here;
   logic [IDX_W-1:0]         slot;
   logic [PW-1:0]            slot_ext, pos_ext, cnt_ext;
   logic                     accept, dup, full, bad, do_ins, do_del;

   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);

   // Sequencer: accept, compare in every cell, then commit.
   always_comb begin
      case (state_ff)
         S_IDLE:   state_in = accept ? S_CMP : S_IDLE;
         S_CMP:    state_in = S_COMMIT;
         S_COMMIT: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         strobe_ff <= strobe_in;
      end
   end

   // Hold the accepted item for the compare and commit cycles.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_op;
         value_ff <= req_value;
         pos_ff   <= req_position;
      end
      status_ff <= status_in;
      count_ff  <= count_in;
      where_ff  <= where_in;
   end

   // The cell chain.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                     left_lt;
      logic signed [DATA_W-1:0] left_entry, right_entry;

      assign here_valid[i] = (PW'(i) < cnt_ext);
      assign del_here[i]   = (PW'(i) >= pos_ext);

      if (i == 0) begin : g_first
         assign left_lt    = 1'b1;
         assign left_entry = value_ff;
      end else begin : g_left
         assign left_lt    = lt[i-1];
         assign left_entry = entries[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = entries[i];
      end else begin : g_right
         assign right_entry = entries[i+1];
      end

      ssid_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .value       (value_ff),
         .here_valid  (here_valid[i]),
         .del_here    (del_here[i]),
         .left_lt     (left_lt),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (entries[i]),
         .lt          (lt[i]),
         .eq          (eq[i]),
         .boundary    (boundary[i])
      );
   end

   // Insert position: the single cell where smaller entries end.
   always_comb begin
      slot = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         if (boundary[k]) begin
            slot = slot | IDX_W'(k);
         end
      end
   end

   assign pos_ext  = PW'(pos_ff);
   assign cnt_ext  = PW'(cnt_ff);
   assign slot_ext = PW'(slot);

   // Decide the outcome in the commit cycle.
   assign dup    = |eq;
   assign full   = (cnt_ff == CNT_FULL);
   assign bad    = (pos_ext >= cnt_ext);
   assign do_ins = (state_ff == S_COMMIT) && (op_ff == OP_INSERT) && !dup && !full;
   assign do_del = (state_ff == S_COMMIT) && (op_ff == OP_DELETE) && !bad;

   assign cmd.compare = (state_ff == S_CMP);
   assign cmd.insert  = do_ins;
   assign cmd.remove  = do_del;

   // Result and new count.
   always_comb begin
      cnt_in    = cnt_ff;
      strobe_in = (state_ff == S_COMMIT);
      status_in = ST_DONE;
      where_in  = 4'd0;
      if (op_ff == OP_INSERT) begin
         if (dup) begin
            status_in = ST_DUP;
         end else if (full) begin
            status_in = ST_FULL;
         end else begin
            where_in = slot_ext[3:0];
         end
      end else begin
         if (bad) begin
            status_in = ST_BAD;
         end else begin
            where_in = pos_ff;
         end
      end
      if (do_ins) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_del) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
      count_in = RC_W'(cnt_in);
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_status = status_ff;
   assign rsp_count  = count_ff[4:0];
   assign rsp_where  = where_ff;

   // Checks on the sequencer and the cell chain.
   `SSID_ASSERT_IMPL(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CNT_FULL, "count above capacity")
   `SSID_ASSERT_NEXT(a_accept_cmp, clock, reset, accept, state_ff == S_CMP, "accept did not start compare")
   `SSID_ASSERT_NEXT(a_cnt_hold, clock, reset, state_ff != S_COMMIT, cnt_ff == $past(cnt_ff), "count moved outside commit")
   `SSID_ASSERT_IMPL(a_strobe_src, clock, reset, rsp_strobe, $past(state_ff) == S_COMMIT, "strobe without commit")
   `SSID_ASSERT_IMPL(a_slot_onehot, clock, reset, state_ff == S_COMMIT && !full, $onehot(boundary), "insert position not unique")

endmodule

>>> rtl/ssid_cell.sv
module ssid_cell (
   input  logic                                clock,
   input  ssid_pkg::ssid_cmd_type              cmd,
   input  logic signed [ssid_pkg::DATA_W-1:0]  value,
   input  logic                                here_valid,
   input  logic                                del_here,
   input  logic                                left_lt,
   input  logic signed [ssid_pkg::DATA_W-1:0]  left_entry,
   input  logic signed [ssid_pkg::DATA_W-1:0]  right_entry,
   output logic signed [ssid_pkg::DATA_W-1:0]  entry,
   output logic                                lt,
   output logic                                eq,
   output logic                                boundary
);
   import ssid_pkg::*;

   logic signed [DATA_W-1:0] entry_ff, entry_in;
   logic                     lt_ff, lt_in;
   logic                     eq_ff, eq_in;

   // Compare the stored entry against the new value; empty cells never match.
   always_comb begin
      lt_in = lt_ff;
      eq_in = eq_ff;
      if (cmd.compare) begin
         lt_in = here_valid && (entry_ff < value);
         eq_in = here_valid && (entry_ff == value);
      end
   end

   // Insert moves larger entries up one cell; delete pulls entries down one cell.
   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert && !lt_ff) begin
         entry_in = left_lt ? value : left_entry;
      end else if (cmd.remove && del_here) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      lt_ff    <= lt_in;
      eq_ff    <= eq_in;
   end

   assign entry    = entry_ff;
   assign lt       = lt_ff;
   assign eq       = eq_ff;
   assign boundary = left_lt && !lt_ff;

endmodule

>>> verif/tb_sorted_set_insert_delete_unit.sv
`timescale 1ns / 100ps

module tb_sorted_set_insert_delete_unit;
   import ssid_pkg::*;

   // One expected or observed result of the store.
   typedef struct packed {
      logic [1:0] status;
      logic [4:0] count;
      logic [3:0] where;
   } set_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic                       req_op = OP_INSERT;
   logic signed [DATA_W-1:0]   req_value = '0;
   logic [3:0]                 req_position = '0;
   logic                       rsp_strobe;
   logic [1:0]                 rsp_status;
   logic [4:0]                 rsp_count;
   logic [3:0]                 rsp_where;

   // Shadow copy of the sorted store and its occupancy.
   logic signed [DATA_W-1:0]   shadow_vals [CAPACITY];
   int                         shadow_count = 0;

   set_result_type             pending_results [$];
   set_result_type             oldest;
   int                         error_count = 0;
   int                         items_sent = 0;
   int                         results_checked = 0;
   int                         status_seen [4] = '{0, 0, 0, 0};
   int                         max_gap = 15;

   sorted_set_insert_delete_unit uut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_op       (req_op),
      .req_value    (req_value),
      .req_position (req_position),
      .rsp_strobe   (rsp_strobe),
      .rsp_status   (rsp_status),
      .rsp_count    (rsp_count),
      .rsp_where    (rsp_where)
   );

   // Free-running clock.
   initial begin
      forever #5 clock = ~clock;
   end

   // Applies one item to the shadow store and returns the result it should give.
   function automatic set_result_type apply_set_step(input logic op,
                                                     input logic signed [DATA_W-1:0] value,
                                                     input logic [3:0] pos);
      set_result_type r;
      int             slot;
      bit             found;
      r.status = ST_DONE;
      r.where  = '0;
      slot     = 0;
      found    = 1'b0;
      if (op == OP_INSERT) begin
         for (int i = 0; i < shadow_count; i++) begin
            if (shadow_vals[i] == value) found = 1'b1;
            if (shadow_vals[i] < value) slot = i + 1;
         end
         // A duplicate wins over a full store.
         if (found) begin
            r.status = ST_DUP;
         end else if (shadow_count >= CAPACITY) begin
            r.status = ST_FULL;
         end else begin
            for (int i = shadow_count; i > slot; i--) shadow_vals[i] = shadow_vals[i-1];
            shadow_vals[slot] = value;
            shadow_count++;
            r.where = slot[3:0];
         end
      end else begin
         if (shadow_count == 0 || pos >= shadow_count) begin
            r.status = ST_BAD;
         end else begin
            for (int i = pos; i + 1 < shadow_count; i++) shadow_vals[i] = shadow_vals[i+1];
            shadow_count--;
            r.where = pos;
         end
      end
      r.count = shadow_count[4:0];
      return r;
   endfunction

   // Sends one item after a random gap and records the result it should give.
   // Start is left high so that a back-to-back item is taken without start going low in between.
   task automatic send_item(input logic op, input logic signed [DATA_W-1:0] value,
                            input logic [3:0] pos);
      int gap;
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_op       <= op;
      req_value    <= value;
      req_position <= pos;
      start        <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_results.push_back(apply_set_step(op, value, pos));
      items_sent++;
   endtask

   // Holds the sender off until every outstanding result has come back.
   task automatic wait_for_results();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Picks an insert value: half the time from a narrow range so duplicates are common.
   function automatic logic signed [DATA_W-1:0] pick_value();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel <= 4) return $signed(32'($urandom_range(0, 23))) - 12;
      if (sel == 5 && shadow_count > 0) return shadow_vals[$urandom_range(0, shadow_count - 1)];
      if (sel == 6) begin
         case ($urandom_range(0, 3))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sh0000_0000;
            default: return -32'sd1;
         endcase
      end
      return $urandom();
   endfunction

   // Picks a delete position: mostly a valid one, sometimes any.
   function automatic logic [3:0] pick_position();
      if (shadow_count > 0 && $urandom_range(0, 3) != 0)
         return 4'($urandom_range(0, shadow_count - 1));
      return 4'($urandom_range(0, 15));
   endfunction

   // Empty store, bad positions, extremes, duplicates and the only-entry delete.
   task automatic test_empty_and_extremes();
      send_item(OP_DELETE, 32'sd0, 4'd0);
      send_item(OP_DELETE, -32'sd1, 4'd15);
      send_item(OP_INSERT, 32'sd0, 4'd0);
      send_item(OP_INSERT, 32'sd0, 4'd15);
      send_item(OP_DELETE, 32'sd0, 4'd1);
      send_item(OP_DELETE, 32'sd0, 4'd0);
      send_item(OP_DELETE, 32'sd0, 4'd0);
      send_item(OP_INSERT, 32'sh8000_0000, 4'd0);
      send_item(OP_INSERT, 32'sh7FFF_FFFF, 4'd0);
      send_item(OP_INSERT, -32'sd1, 4'd0);
      send_item(OP_INSERT, 32'sd1, 4'd0);
      send_item(OP_INSERT, 32'sd0, 4'd0);
      send_item(OP_INSERT, 32'sh7FFF_FFFF, 4'd0);
      send_item(OP_INSERT, 32'sh8000_0000, 4'd0);
      send_item(OP_DELETE, 32'sd0, 4'd4);
      send_item(OP_DELETE, 32'sd0, 4'd0);
      send_item(OP_DELETE, 32'sd0, 4'd1);
      send_item(OP_DELETE, 32'sd0, 4'd15);
      wait_for_results();
   endtask

   // Fills the store, then tries inserts and deletes against a full store.
   task automatic test_full_store();
      logic signed [DATA_W-1:0] v;
      for (int i = 0; i < CAPACITY; i++) begin
         // Stepping by 7 spreads inserts over the front, middle and back.
         v = ($signed(32'((i * 7) % CAPACITY)) - 8) * 1000;
         send_item(OP_INSERT, v, 4'd0);
      end
      send_item(OP_INSERT, 32'sh7FFF_FFFF, 4'd0);
      send_item(OP_INSERT, 32'sh8000_0000, 4'd0);
      send_item(OP_INSERT, -32'sd3000, 4'd0);
      send_item(OP_DELETE, 32'sd0, 4'd15);
      send_item(OP_DELETE, 32'sd0, 4'd0);
      send_item(OP_INSERT, 32'sh7FFF_FFFF, 4'd0);
      wait_for_results();
   endtask

   // Random mix in phases that lean toward filling, draining or churning.
   task automatic test_random_mix(input int total);
      int insert_pct [8] = '{85, 15, 50, 70, 30, 95, 5, 50};
      int per_phase;
      per_phase = total / 8;
      for (int p = 0; p < 8; p++) begin
         // Every third phase runs with no sender gaps at all.
         max_gap = (p % 3 == 2) ? 0 : 15;
         for (int k = 0; k < per_phase; k++) begin
            if ($urandom_range(0, 99) < insert_pct[p])
               send_item(OP_INSERT, pick_value(), 4'($urandom_range(0, 15)));
            else
               send_item(OP_DELETE, $urandom(), pick_position());
         end
         if (p == 3) wait_for_results();
      end
      max_gap = 15;
      wait_for_results();
   endtask

   // Compares each strobed result with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         status_seen[rsp_status]++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result status=%0d count=%0d where=%0d",
                     $time, rsp_status, rsp_count, rsp_where);
            error_count++;
         end else begin
            oldest = pending_results.pop_front();
            results_checked++;
            if (rsp_status !== oldest.status) begin
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, oldest.status, rsp_status);
               error_count++;
            end
            if (rsp_count !== oldest.count) begin
               $display("%0t: count mismatch, expected %0d, actual %0d",
                        $time, oldest.count, rsp_count);
               error_count++;
            end
            if (rsp_where !== oldest.where) begin
               $display("%0t: where mismatch, expected %0d, actual %0d",
                        $time, oldest.where, rsp_where);
               error_count++;
            end
         end
      end
   end

   // Guards against a hang.
   initial begin
      #2ms;
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("FAIL");
      $finish;
   end

   // Test sequence.
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_and_extremes();
      test_full_store();
      test_random_mix(800);
      repeat (10) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, pending_results.size());
         error_count++;
      end
      $display("Sent %0d items and checked %0d results against the shadow store.",
               items_sent, results_checked);
      $display("Status mix: done %0d, duplicate %0d, full %0d, bad delete %0d.",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> sorted_set_insert_delete_unit.f
+incdir+rtl
rtl/ssid_pkg.sv
rtl/ssid_cell.sv
rtl/sorted_set_insert_delete_unit.sv
verif/tb_sorted_set_insert_delete_unit.sv
